// ----- rtl/core/mp22_pkg.sv -----
package mp22_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IN_WIDTH      = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam int CFG_W = 16;
  localparam int DIM_W = 13;
  localparam int CH_W  = 16;
  localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;

  typedef struct packed {
    logic [31:0] pooled_value;
    logic        end_of_plane;
    logic        end_of_tensor;
  } result_t;

  // float a < b on raw single bits
  function automatic logic flt_lt(logic [31:0] a, logic [31:0] b);
    logic a_nan, b_nan, a_zero, b_zero;
    logic r;
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan || (a_zero && b_zero)) r = 1'b0;
    else if (a[31] != b[31]) r = a[31];
    else if (a[31]) r = a[30:0] > b[30:0];
    else r = a[30:0] < b[30:0];
    return r;
  endfunction

  function automatic logic [31:0] fmax_bits(logic [31:0] a, logic [31:0] b);
    return flt_lt(a, b) ? b : a;
  endfunction

endpackage

// ----- rtl/core/mp22_stream_if.sv -----
interface mp22_stream_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mp22_ram.sv -----
module mp22_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/max_pool_2x2_stride2.sv -----
// pipeline (two stages): last input pixel into stage 2 registers, then output register
// throughput: one pixel per cycle unless stalled; line RAM: one read and one write a cycle
// reset: synchronous active-low rst_n clears counters, pixel hold, stage valids and
//   registers (width 2, height 2, one channel); line buffer is not cleared
module max_pool_2x2_stride2 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mp22_stream_if.sink                in_if,
  mp22_stream_if.source              out_if,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mp22_pkg::CFG_W-1:0] cfg_data
);
  localparam int HALF  = MAX_WIDTH / 2;
  localparam int AW    = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int DW    = mp22_pkg::DIM_W;

  logic [DW-1:0]            in_width_r, in_height_r;
  logic [mp22_pkg::CH_W-1:0] channel_count_r;
  logic [CW-1:0]            col_r;
  logic [DW-1:0]            row_r;
  logic [mp22_pkg::CH_W-1:0] plane_r;
  logic [31:0]              hold_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r <= DW'(2); in_height_r <= DW'(2); channel_count_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mp22_pkg::REG_IN_WIDTH:      in_width_r <= cfg_data[DW-1:0];
        mp22_pkg::REG_IN_HEIGHT:     in_height_r <= cfg_data[DW-1:0];
        mp22_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits
  logic [CW-1:0]   w_eff;
  logic [DW-1:0]   h_eff;
  logic [16:0]     ch_eff;
  always_comb begin
    if (in_width_r < DW'(2)) w_eff = CW'(2);
    else if (32'(in_width_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(in_width_r);
    if (in_height_r < DW'(2)) h_eff = DW'(2);
    else if (in_height_r > mp22_pkg::HEIGHT_MAX) h_eff = mp22_pkg::HEIGHT_MAX;
    else h_eff = in_height_r;
    ch_eff = (channel_count_r == '0) ? 17'd1 : {1'b0, channel_count_r};
  end

  // stage 2 pipeline registers
  logic        s_v_r, s_emit_r, s_eop_r, s_eot_r, s_fwd_r;
  logic [31:0] s_pm_r, s_fwd_data_r;
  logic [AW-1:0] s_idx_r;
  logic        ram_we_r;
  logic [AW-1:0] ram_waddr_r;
  logic [31:0] ram_wdata_r, ram_rdata;
  logic        out_v_r;
  mp22_pkg::result_t out_r;

  logic stall, acc;
  assign stall = out_v_r && !out_if.ready && s_v_r && s_emit_r;
  assign in_if.ready = !stall;
  assign acc = in_if.valid && in_if.ready;

  logic [AW-1:0] idx, rd_idx;
  logic          in_range, odd_col, odd_row, eop, col_wrap, row_wrap;
  logic [31:0]   pm;
  assign idx      = AW'(col_r >> 1);
  assign in_range = 32'(col_r >> 1) < HALF;
  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];
  assign pm       = mp22_pkg::fmax_bits(hold_r, in_if.data);
  assign eop = ({1'b0, col_r} >= {1'b0, w_eff} - (CW+1)'(1) - (CW+1)'(w_eff[0]))
            && ({1'b0, row_r} >= {1'b0, h_eff} - (DW+1)'(1) - (DW+1)'(h_eff[0]));
  assign col_wrap = ({1'b0, col_r} + (CW+1)'(1)) >= {1'b0, w_eff};
  assign row_wrap = ({1'b0, row_r} + (DW+1)'(1)) >= {1'b0, h_eff};

  // keep rereading the staged entry while the stage waits
  assign rd_idx = stall ? s_idx_r : idx;

  mp22_ram #(.WIDTH(32), .DEPTH(HALF)) u_line (
    .clk(clk), .we(ram_we_r), .waddr(ram_waddr_r), .wdata(ram_wdata_r),
    .raddr(rd_idx), .rdata(ram_rdata)
  );

  // counters, hold, write staging, read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; plane_r <= '0; hold_r <= '0;
      s_v_r <= 1'b0; ram_we_r <= 1'b0;
    end else begin
      ram_we_r <= 1'b0;
      if (!stall) s_v_r <= 1'b0;
      if (acc) begin
        s_v_r    <= odd_col && odd_row;
        s_emit_r <= odd_col && odd_row;
        s_pm_r   <= pm;
        s_idx_r  <= idx;
        s_eop_r  <= eop;
        s_eot_r  <= eop && ({1'b0, plane_r} + 17'd1 >= ch_eff);
        // write in flight to the same entry is forwarded past the ram read
        s_fwd_r      <= ram_we_r && (ram_waddr_r == idx) || !in_range;
        s_fwd_data_r <= in_range ? ram_wdata_r : 32'd0;
        if (!odd_col) hold_r <= in_if.data;
        else if (!odd_row && in_range) begin
          ram_we_r <= 1'b1; ram_waddr_r <= idx; ram_wdata_r <= pm;
        end
        if (col_wrap) begin
          col_r <= '0;
          if (row_wrap) begin
            row_r <= '0;
            plane_r <= ({1'b0, plane_r} + 17'd1 >= ch_eff) ? '0 : plane_r + 16'd1;
          end else row_r <= row_r + DW'(1);
        end else col_r <= col_r + CW'(1);
      end
    end
  end

  // output register
  logic [31:0] top;
  assign top = s_fwd_r ? s_fwd_data_r : ram_rdata;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else begin
      if (out_if.ready) out_v_r <= 1'b0;
      if (s_v_r && !stall) begin
        out_v_r <= 1'b1;
        out_r.pooled_value  <= mp22_pkg::fmax_bits(top, s_pm_r);
        out_r.end_of_plane  <= s_eop_r;
        out_r.end_of_tensor <= s_eot_r;
      end
    end
  end
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

`ifndef ASSERT_OFF
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> s_v_r) else $error("staged word lost under stall");
  a_eot_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.end_of_tensor |-> out_r.end_of_plane)
    else $error("end of tensor without end of plane");
  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> !in_if.ready) else $error("input taken while stalled");
`endif
endmodule

// ----- tb/max_pool_2x2_stride2_tb.sv -----
module max_pool_2x2_stride2_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LINE_DEPTH = 2048;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [mp22_pkg::CFG_W-1:0] cfg_data;

  mp22_stream_if #(.W(32)) pix_ch ();
  mp22_stream_if #(.W($bits(mp22_pkg::result_t))) pool_ch ();

  max_pool_2x2_stride2 dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(pix_ch.sink),
    .out_if(pool_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  logic [31:0] pixel_q[$];
  mp22_pkg::result_t pooled_q[$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;

  // predictor state
  int unsigned pool_width = 2, pool_height = 2, pool_planes = 1;
  int unsigned col_pos = 0, row_pos = 0, plane_pos = 0;
  logic [31:0] held_pixel = '0;
  logic [31:0] top_pair_max[LINE_DEPTH];

  // ordering key: larger key means larger float, both zeros equal
  function automatic logic [31:0] order_key(logic [31:0] v);
    if (v[30:0] == 31'd0) return 32'h8000_0000;
    return v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic logic is_nan(logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  // larger of two pixels, the first one kept on ties and on any nan
  function automatic logic [31:0] larger_pixel(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return a;
    return (order_key(a) < order_key(b)) ? b : a;
  endfunction

  task automatic pool_step(logic [31:0] px);
    int unsigned w, h, ch, last_col, last_row, slot;
    logic [31:0] pair_max;
    mp22_pkg::result_t r;
    w = pool_width < 2 ? 2 : (pool_width > 4096 ? 4096 : pool_width);
    h = pool_height < 2 ? 2 : (pool_height > 4096 ? 4096 : pool_height);
    ch = pool_planes == 0 ? 1 : pool_planes;
    last_col = 2 * (w / 2) - 1;
    last_row = 2 * (h / 2) - 1;
    slot = col_pos / 2;
    if (col_pos % 2 == 0) begin
      held_pixel = px;
    end else begin
      pair_max = larger_pixel(held_pixel, px);
      if (row_pos % 2 == 0) begin
        top_pair_max[slot] = pair_max;
      end else begin
        r.pooled_value = larger_pixel(top_pair_max[slot], pair_max);
        r.end_of_plane = (col_pos >= last_col) && (row_pos >= last_row);
        r.end_of_tensor = r.end_of_plane && (plane_pos + 1 >= ch);
        pooled_q.push_back(r);
      end
    end
    // raster counters
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        plane_pos = (plane_pos + 1 >= ch) ? 0 : plane_pos + 1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // input side accepts and result checks
  always @(posedge clk) begin
    mp22_pkg::result_t got;
    mp22_pkg::result_t want;
    if (rst_n && pix_ch.valid && pix_ch.ready && pixel_q.size() > 0) begin
      pool_step(pixel_q.pop_front());
      accepted++;
    end
    if (rst_n && pool_ch.valid && pool_ch.ready) begin
      got = mp22_pkg::result_t'(pool_ch.data);
      if (pooled_q.size() == 0) begin
        report("unexpected word", got.pooled_value, 32'h0);
      end else begin
        want = pooled_q.pop_front();
        if (got.pooled_value !== want.pooled_value)
          report("pooled_value", got.pooled_value, want.pooled_value);
        if (got.end_of_plane !== want.end_of_plane)
          report("end_of_plane", 32'(got.end_of_plane), 32'(want.end_of_plane));
        if (got.end_of_tensor !== want.end_of_tensor)
          report("end_of_tensor", 32'(got.end_of_tensor), 32'(want.end_of_tensor));
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n || pixel_q.size() == 0) begin
      pix_ch.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      pix_ch.valid <= 1'b0;
    end else begin
      pix_ch.valid <= 1'b1;
      pix_ch.data <= pixel_q[0];
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int stall_mode = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    if (!hold_done && accepted >= 100) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      pool_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: pool_ch.ready <= 1'b1;
        1: pool_ch.ready <= ($urandom_range(0, 1) == 0);
        default: pool_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [31:0] pick_pixel();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: begin
        case ($urandom_range(0, 7))
          0: v = 32'h0000_0000;
          1: v = 32'h8000_0000;
          2: v = 32'h7f80_0000;
          3: v = 32'hff80_0000;
          4: v = 32'h7fc0_0000;
          5: v = 32'hffff_ffff;
          6: v = 32'h0000_0001;
          default: v = 32'h7f7f_ffff;
        endcase
      end
      default: begin
        // close values so compares hinge on low bits
        v = {1'($urandom_range(0, 1)), 8'(126 + $urandom_range(0, 2)), 23'($urandom())};
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[mp22_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one full tensor at a given setting; block idle on entry
  task automatic run_tensor(int unsigned w, int unsigned h, int unsigned ch, logic directed);
    int unsigned we, he, ce, n;
    logic [31:0] specials[16];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'h3f80_0000, 32'hffff_ffff, 32'h0000_0001,
                 32'h8000_0001, 32'hbf80_0000, 32'h7f7f_ffff, 32'hff7f_ffff,
                 32'h3f80_0001, 32'h3f80_0000, 32'h0000_0000, 32'h8000_0000};
    write_reg(mp22_pkg::REG_IN_WIDTH, w);
    write_reg(mp22_pkg::REG_IN_HEIGHT, h);
    write_reg(mp22_pkg::REG_CHANNEL_COUNT, ch);
    pool_width = w;
    pool_height = h;
    pool_planes = ch;
    we = w < 2 ? 2 : (w > 4096 ? 4096 : w);
    he = h < 2 ? 2 : (h > 4096 ? 4096 : h);
    ce = ch == 0 ? 1 : ch;
    n = we * he * ce;
    for (int unsigned i = 0; i < n; i++)
      pixel_q.push_back((directed && i < 16) ? specials[i] : pick_pixel());
    wait (pixel_q.size() == 0 && pooled_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned w, h, ch;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mp22_pkg::REG_IN_WIDTH;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.data = '0;
    pool_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: special values, low clamps, odd edges, many planes
    run_tensor(4, 4, 1, 1'b1);
    run_tensor(0, 1, 0, 1'b0);
    run_tensor(5, 3, 2, 1'b0);
    run_tensor(3, 5, 1, 1'b0);
    run_tensor(2, 2, 20, 1'b0);

    // random settings
    random_pixels = 0;
    while (random_pixels < 300) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 7);
      ch = $urandom_range(1, 3);
      random_pixels += w * h * ch;
      run_tensor(w, h, ch, 1'b0);
    end

    wait (pooled_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
